// ===== src/fosc_pkg.sv =====
package fosc_pkg;

  localparam int COEFF_FRAC_BITS_DEF = 26;
  localparam int CORDIC_STAGES_DEF   = 28;
  localparam int SR_W   = 18;
  localparam int GAIN_W = 32;
  localparam int FC_W   = 17;
  localparam int CO_W   = 32;
  localparam int ST_W   = 2;
  localparam logic [SR_W-1:0] SR_RESET = 18'd48000;
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  localparam logic [ST_W-1:0] ST_OK  = 2'd0;
  localparam logic [ST_W-1:0] ST_INV = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT = 2'd2;

  // Division pipeline: frac = (fc << 46) / fs
  localparam int FDIV_W  = 63;  // dividend width
  localparam int FDIV_ST = 63;

  // atan(2^-i) in Q60, truncated series
  function automatic logic signed [63:0] atan_q60(input int i);
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int e;
    sum = '0;
    if (i == 0) begin
      sum = $signed(PI_Q60 >> 2);
    end else begin
      for (int k = 0; k < 31; k++) begin
        e = i * (2 * k + 1);
        if (e <= 60) begin
          term = $signed((64'd1 << (60 - e)) / 64'(2 * k + 1));
          if (k % 2 == 1) sum = sum - term;
          else sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

  typedef struct packed {
    logic              high;
    logic              invalid;
    logic [GAIN_W-1:0] gain;
  } tag_t;

endpackage

// ===== src/fosc_pipe_cell.sv =====
// One step of the valid chain.
module fosc_pipe_cell
  import fosc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  output logic vout
);
  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end
endmodule

// ===== src/fosc_div_cell.sv =====
// One restoring-division step per cell: quotient bit from dividend bit position POS.
module fosc_div_cell
  import fosc_pkg::*;
#(
  parameter int NW = 64,
  parameter int DW = 64,
  parameter int POS = 0,
  parameter int XW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_in,
  input  logic [DW-1:0] den_in,
  input  logic [DW-1:0] rem_in,
  input  logic [NW-1:0] q_in,
  input  logic [XW-1:0] x_in,
  output logic [NW-1:0] num_out,
  output logic [DW-1:0] den_out,
  output logic [DW-1:0] rem_out,
  output logic [NW-1:0] q_out,
  output logic [XW-1:0] x_out
);
  logic [DW:0] sh;
  logic        ge;
  always_comb begin
    sh = {rem_in, num_in[POS]};
    ge = sh >= {1'b0, den_in};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      num_out <= num_in;
      den_out <= den_in;
      rem_out <= ge ? DW'(sh - {1'b0, den_in}) : sh[DW-1:0];
      q_out   <= q_in | (NW'(ge) << POS);
      x_out   <= x_in;
    end
  end
endmodule

// ===== src/fosc_cordic_cell.sv =====
// One CORDIC rotation stage.
module fosc_cordic_cell
  import fosc_pkg::*;
#(
  parameter int I = 0,
  parameter int XW = 8
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] x_in,
  input  logic signed [63:0] y_in,
  input  logic signed [63:0] z_in,
  input  logic [XW-1:0]      t_in,
  output logic signed [63:0] x_out,
  output logic signed [63:0] y_out,
  output logic signed [63:0] z_out,
  output logic [XW-1:0]      t_out
);
  localparam logic signed [63:0] A = atan_q60(I);
  logic signed [63:0] dx, dy;
  always_comb begin
    dx = y_in >>> I;
    dy = x_in >>> I;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[63]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - A;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + A;
      end
      t_out <= t_in;
    end
  end
endmodule

// ===== src/first_order_shelf_coeff_design_top.sv =====
// First-order shelving filter coefficient designer.
// Input channel (in_valid/in_ready): opcode, shelf_gain, corner_hz per transaction.
// Output channel (out_valid/out_ready): coeff_b0, coeff_b1, coeff_a1, status.
// Config channel (cfg_valid/cfg_ready): sample_rate_hz, to be written by the
// user only while idle; the block itself does not enforce this. One result
// per input, in order. Throughput: one transaction per cycle unless the output stalls.
// The pipeline is a chain of cells: the angle divider (63 cells), the angle
// multiply (3 cells, 15 bits each), the CORDIC rotation (CORDIC_STAGES cells),
// the cosine/sine output register, the square root (32 cells), the numerator
// products and sums (2 cells), three parallel quotient dividers
// (COEFF_FRAC_BITS + 65 cells) and the rounding output register.
// The whole chain advances only when the output register is free or taken,
// so a stalled receiver freezes the pipeline and in_ready drops; nothing is
// lost. Reset clears all valid bits and loads a sample rate of 48000 Hz.
module first_order_shelf_coeff_design_top
  import fosc_pkg::*;
#(
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   opcode,
  input  logic [GAIN_W-1:0]      shelf_gain,
  input  logic [FC_W-1:0]        corner_hz,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [CO_W-1:0] coeff_b0,
  output logic signed [CO_W-1:0] coeff_b1,
  output logic signed [CO_W-1:0] coeff_a1,
  output logic [ST_W-1:0]        status,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SR_W-1:0]        sample_rate_hz
);
  localparam int TW = $bits(tag_t);
  localparam int QD = 64;
  localparam int NSTAGE = FDIV_ST + 3 + CORDIC_STAGES + 1 + 32 + 2
                        + (64 + COEFF_FRAC_BITS + 1) + 1;

  logic [SR_W-1:0] fs;
  logic            en;
  logic [NSTAGE:0] v;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fs <= SR_RESET;
    end else if (cfg_valid) begin
      fs <= sample_rate_hz;
    end
  end

  // valid chain
  assign v[0] = in_valid;
  for (genvar k = 0; k < NSTAGE; k++) begin : g_v
    fosc_pipe_cell u_v (
      .clk(clk), .rst(rst), .en(en), .vin(v[k]), .vout(v[k+1])
    );
  end
  assign out_valid = v[NSTAGE];

  // ---------- stage A: angle divider, frac = (fc<<46)/fs ----------
  localparam int AX = TW + FC_W;
  tag_t tag0;
  always_comb begin
    tag0.high    = opcode;
    tag0.gain    = shelf_gain;
    tag0.invalid = (shelf_gain == '0) || (fs == '0) || ({1'b0, corner_hz, 1'b0} >= 19'(fs));
  end
  logic [FDIV_W-1:0] an [FDIV_ST+1];
  logic [SR_W-1:0]   ad [FDIV_ST+1];
  logic [SR_W-1:0]   ar [FDIV_ST+1];
  logic [FDIV_W-1:0] aq [FDIV_ST+1];
  logic [AX-1:0]     ax [FDIV_ST+1];
  assign an[0] = {corner_hz, 46'd0};
  assign ad[0] = fs;
  assign ar[0] = '0;
  assign aq[0] = '0;
  assign ax[0] = {tag0, corner_hz};
  for (genvar k = 0; k < FDIV_ST; k++) begin : g_adiv
    fosc_div_cell #(.NW(FDIV_W), .DW(SR_W), .POS(FDIV_W-1-k), .XW(AX)) u_c (
      .clk(clk), .en(en),
      .num_in(an[k]), .den_in(ad[k]), .rem_in(ar[k]), .q_in(aq[k]), .x_in(ax[k]),
      .num_out(an[k+1]), .den_out(ad[k+1]), .rem_out(ar[k+1]), .q_out(aq[k+1]),
      .x_out(ax[k+1])
    );
  end

  // angle = (PI_Q60 * frac) >> 46; frac < 2^45, 15 multiplier bits per cell
  logic [44:0]        fr;
  logic [108:0]       zp1, zp2, zp;
  logic [29:0]        zf1;
  logic [14:0]        zf2;
  tag_t               tgm1, tgm2;
  logic signed [63:0] z0;
  tag_t               tag1;
  assign fr = aq[FDIV_ST][44:0];
  assign zp = zp2 + (109'(79'(PI_Q60) * 79'(zf2)) << 30);
  always_ff @(posedge clk) begin
    if (en) begin
      zp1  <= 109'(79'(PI_Q60) * 79'(fr[14:0]));
      zf1  <= fr[44:15];
      tgm1 <= ax[FDIV_ST][AX-1 -: TW];
      zp2  <= zp1 + (109'(79'(PI_Q60) * 79'(zf1[14:0])) << 15);
      zf2  <= zf1[29:15];
      tgm2 <= tgm1;
      z0   <= {1'b0, zp[108:46]};
      tag1 <= tgm2;
    end
  end

  // ---------- stage B: CORDIC ----------
  logic signed [63:0] cx [CORDIC_STAGES+1];
  logic signed [63:0] cy [CORDIC_STAGES+1];
  logic signed [63:0] cz [CORDIC_STAGES+1];
  logic [TW-1:0]      ct [CORDIC_STAGES+1];
  assign cx[0] = 64'sd1 <<< 58;
  assign cy[0] = '0;
  assign cz[0] = z0;
  assign ct[0] = tag1;
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cor
    fosc_cordic_cell #(.I(k), .XW(TW)) u_c (
      .clk(clk), .en(en),
      .x_in(cx[k]), .y_in(cy[k]), .z_in(cz[k]), .t_in(ct[k]),
      .x_out(cx[k+1]), .y_out(cy[k+1]), .z_out(cz[k+1]), .t_out(ct[k+1])
    );
  end

  logic [33:0] c_r, s_r;
  tag_t        tag2;
  always_ff @(posedge clk) begin
    if (en) begin
      c_r  <= (cx[CORDIC_STAGES] > 0) ? cx[CORDIC_STAGES][63:30] : '0;
      s_r  <= (cy[CORDIC_STAGES] > 0) ? cy[CORDIC_STAGES][63:30] : '0;
      tag2 <= ct[CORDIC_STAGES];
    end
  end

  // ---------- stage C: isqrt(g<<32), one result bit per cell ----------
  localparam int SX = TW + 68;
  logic [63:0] sv [33];
  logic [33:0] sr [33];
  logic [31:0] sq [33];
  logic [SX-1:0] sx [33];
  assign sv[0] = {tag2.gain, 32'd0};
  assign sr[0] = '0;
  assign sq[0] = '0;
  assign sx[0] = {tag2, c_r, s_r};
  for (genvar k = 0; k < 32; k++) begin : g_sq
    logic [33:0] rr;
    logic [35:0] trial;
    always_comb begin
      rr    = {sr[k][31:0], sv[k][63-2*k -: 2]};
      trial = {2'b00, sq[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sv[k+1] <= sv[k];
        if ({2'b0, rr} >= trial) begin
          sr[k+1] <= 34'({2'b0, rr} - trial);
          sq[k+1] <= {sq[k][30:0], 1'b1};
        end else begin
          sr[k+1] <= rr;
          sq[k+1] <= {sq[k][30:0], 1'b0};
        end
        sx[k+1] <= sx[k];
      end
    end
  end

  // ---------- stage D: products ----------
  tag_t        tag3;
  logic [33:0] c3, s3;
  logic [31:0] r3;
  assign tag3 = sx[32][SX-1 -: TW];
  assign c3   = sx[32][67:34];
  assign s3   = sx[32][33:0];
  assign r3   = sq[32];

  logic [63:0] p_sr, p_gc, p_cr, p_gs, p_cs, p_ss;
  tag_t        tag4;
  always_ff @(posedge clk) begin
    if (en) begin
      p_sr <= 64'(s3) * 64'(r3);
      p_cr <= 64'(c3) * 64'(r3);
      p_gc <= 64'({tag3.gain, 2'b00}) * 64'(c3);
      p_gs <= 64'({tag3.gain, 2'b00}) * 64'(s3);
      p_cs <= 64'(c3) << 30;
      p_ss <= 64'(s3) << 30;
      tag4 <= tag3;
    end
  end

  logic signed [63:0] n0, n1, na;
  logic [63:0]        dn;
  tag_t               tag5;
  always_ff @(posedge clk) begin
    if (en) begin
      if (tag4.high) begin
        n0 <= $signed(p_gc + p_sr);
        n1 <= $signed(p_sr - p_gc);
        na <= $signed(p_sr - p_cs);
        dn <= p_cs + p_sr;
      end else begin
        n0 <= $signed(p_cr + p_gs);
        n1 <= $signed(p_gs - p_cr);
        na <= $signed(p_ss - p_cr);
        dn <= p_cr + p_ss;
      end
      tag5 <= tag4;
    end
  end

  // ---------- stage E: three quotient chains ----------
  // q = floor(mag * 2^(F+1) / den); big if q > 2^(35+F)
  localparam int QX = TW + 3;
  logic [63:0] den5;
  assign den5 = (dn == '0) ? 64'd1 : dn;
  logic [63:0] mg [3];
  logic [2:0]  ng;
  assign ng = {n0[63], n1[63], na[63]};
  assign mg[0] = n0[63] ? 64'(-n0) : 64'(n0);
  assign mg[1] = n1[63] ? 64'(-n1) : 64'(n1);
  assign mg[2] = na[63] ? 64'(-na) : 64'(na);

  localparam int NWQ = 64 + COEFF_FRAC_BITS + 1;
  logic [NWQ-1:0] qq  [3];
  logic           qbig [3];
  logic [QX-1:0]  qx_o;
  for (genvar j = 0; j < 3; j++) begin : g_q
    logic [NWQ-1:0] nn [NWQ+1];
    logic [QD-1:0]  dd [NWQ+1];
    logic [QD-1:0]  rm [NWQ+1];
    logic [NWQ-1:0] qa [NWQ+1];
    logic [QX-1:0]  xx [NWQ+1];
    assign nn[0] = {mg[j], {(COEFF_FRAC_BITS+1){1'b0}}};
    assign dd[0] = den5;
    assign rm[0] = '0;
    assign qa[0] = '0;
    assign xx[0] = {tag5, ng};
    for (genvar k = 0; k < NWQ; k++) begin : g_c
      fosc_div_cell #(.NW(NWQ), .DW(QD), .POS(NWQ-1-k), .XW(QX)) u_c (
        .clk(clk), .en(en),
        .num_in(nn[k]), .den_in(dd[k]), .rem_in(rm[k]), .q_in(qa[k]), .x_in(xx[k]),
        .num_out(nn[k+1]), .den_out(dd[k+1]), .rem_out(rm[k+1]), .q_out(qa[k+1]),
        .x_out(xx[k+1])
      );
    end
    assign qq[j]   = qa[NWQ];
    assign qbig[j] = qa[NWQ] > (NWQ'(1) << (35 + COEFF_FRAC_BITS));
    if (j == 0) begin : g_x
      assign qx_o = xx[NWQ];
    end
  end

  // Remaining valid-chain stages not covered by cells above are balanced here.
  localparam int USED = FDIV_ST + 3 + CORDIC_STAGES + 1 + 32 + 2 + NWQ;
  localparam int PAD  = NSTAGE - USED - 1;
  logic [NWQ-1:0] pq [3][PAD+1];
  logic           pb [3][PAD+1];
  logic [QX-1:0]  px [PAD+1];
  for (genvar j = 0; j < 3; j++) begin : g_pj
    assign pq[j][0] = qq[j];
    assign pb[j][0] = qbig[j];
  end
  assign px[0] = qx_o;
  for (genvar k = 0; k < PAD; k++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < 3; j++) begin
          pq[j][k+1] <= pq[j][k];
          pb[j][k+1] <= pb[j][k];
        end
        px[k+1] <= px[k];
      end
    end
  end

  // ---------- output: round, saturate, zero invalid results ----------
  tag_t            tagf;
  logic [2:0]      ngf;
  logic [NWQ-1:0]  rq [3];
  logic signed [CO_W-1:0] co [3];
  logic [2:0]      st;
  assign tagf = px[PAD][QX-1 -: TW];
  assign ngf  = px[PAD][2:0];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rq[j] = (pq[j][PAD] + NWQ'(1)) >> 1;
      if (ngf[2-j]) begin
        st[j] = pb[j][PAD] || rq[j] > (NWQ'(1) << 31);
        co[j] = st[j] ? {1'b1, 31'd0} : CO_W'(-rq[j]);
      end else begin
        st[j] = pb[j][PAD] || rq[j] > ((NWQ'(1) << 31) - NWQ'(1));
        co[j] = st[j] ? {1'b0, {31{1'b1}}} : CO_W'(rq[j]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (tagf.invalid) begin
        coeff_b0 <= '0;
        coeff_b1 <= '0;
        coeff_a1 <= '0;
        status   <= ST_INV;
      end else begin
        coeff_b0 <= co[0];
        coeff_b1 <= co[1];
        coeff_a1 <= co[2];
        status   <= (|st) ? ST_SAT : ST_OK;
      end
    end
  end
endmodule

// ===== src/fosc_checker.sv =====
module fosc_checker
  import fosc_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [ST_W-1:0] status,
  input logic [CO_W-1:0] coeff_b0
);
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("accepts under stall");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)) else $error("drop");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3) else $error("bad status");
  a_inv: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_INV |-> coeff_b0 == '0) else $error("invalid nonzero");
endmodule

bind first_order_shelf_coeff_design_top fosc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status), .coeff_b0(coeff_b0)
);
